// ===== rtl/jsuc_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape package
// Payload types, decoder phases, status codes and the result group record
// shared by the JSON string decoder.
// ----------------------------------------------------------------------------
package jsuc_pkg;

   // Default number of result groups the output queue can hold.
   localparam int GRP_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_document;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic [3:0] status;
      logic       last;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_BODY = 3'd1,
      PH_ESC  = 3'd2,
      PH_HEX1 = 3'd3,
      PH_BSL  = 3'd4,
      PH_U    = 3'd5,
      PH_HEX2 = 3'd6,
      PH_RAW  = 3'd7
   } phase_type;

   typedef enum logic [3:0] {
      ST_BUSY    = 4'd0,
      ST_DONE    = 4'd1,
      ST_NOQUOTE = 4'd2,
      ST_CTRL    = 4'd3,
      ST_ESC     = 4'd4,
      ST_HEX     = 4'd5,
      ST_SURR    = 4'd6,
      ST_UTF8    = 4'd7,
      ST_EARLY   = 4'd8
   } status_type;

   // All result items caused by one request: either a single status item or
   // one to four data bytes (last_idx is the index of the final byte).
   typedef struct packed {
      logic            is_status;
      status_type      status;
      logic [1:0]      last_idx;
      logic [3:0][7:0] bytes;
   } grp_type;

endpackage

// ===== rtl/json_string_unescape_utf8_check.sv =====
// ----------------------------------------------------------------------------
// JSON string decoder with UTF-8 validation
// Skips leading white space, decodes one quoted JSON string (simple and \u
// escapes, surrogate pairs, validated raw UTF-8) and emits its UTF-8 bytes.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload            Per transfer
//  -------  ---------  -----------------  ----------------------------------
//  req_     in         req_payload_type   one document byte or end marker
//  rsp_     out        rsp_payload_type   one decoded byte or one status
//
// A request is decoded in the cycle in which it is accepted: the decoder state
// and the whole group of results it causes are written at that clock edge, so
// one request can be taken in every cycle while the result queue has room.
// When the queue is empty, the first result item of a request is offered in
// the cycle after it is accepted; results wait in a queue of GRP_DEPTH groups
// and leave one item per cycle while rsp_ready is high, n bytes as n items.
// req_ready is low only while that queue is full. A stall on rsp_ready
// therefore holds up the input only once GRP_DEPTH groups are pending; from
// then on every request waits, including one that would cause no result.
// Synchronous reset returns the decoder to idle and empties the queue; there
// is no clearing pass, so the first request can be taken just after reset.
//
module json_string_unescape_utf8_check #(
   parameter int GRP_DEPTH = jsuc_pkg::GRP_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  jsuc_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output jsuc_pkg::rsp_payload_type rsp_payload
);
   import jsuc_pkg::*;

   localparam int PtrW = (GRP_DEPTH > 1) ? $clog2(GRP_DEPTH) : 1;
   localparam int CntW = $clog2(GRP_DEPTH + 1);

   // Turns a validated code point into its UTF-8 byte group.
   function automatic grp_type encode_cp(input logic [20:0] cp);
      grp_type enc;
      enc = '0;
      enc.is_status = 1'b0;
      enc.status    = ST_BUSY;
      priority if (cp <= 21'h00007F) begin
         enc.last_idx = 2'd0;
         enc.bytes[0] = cp[7:0];
      end else if (cp <= 21'h0007FF) begin
         enc.last_idx = 2'd1;
         enc.bytes[0] = {3'b110, cp[10:6]};
         enc.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp <= 21'h00FFFF) begin
         enc.last_idx = 2'd2;
         enc.bytes[0] = {4'b1110, cp[15:12]};
         enc.bytes[1] = {2'b10, cp[11:6]};
         enc.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         enc.last_idx = 2'd3;
         enc.bytes[0] = {5'b11110, cp[20:18]};
         enc.bytes[1] = {2'b10, cp[17:12]};
         enc.bytes[2] = {2'b10, cp[11:6]};
         enc.bytes[3] = {2'b10, cp[5:0]};
      end
      return enc;
   endfunction

   // ---------------------------------------------------------------------
   // Decoder state
   // ---------------------------------------------------------------------
   phase_type   phase_ff,  phase_in;
   logic [20:0] code_ff,   code_in;
   logic [1:0]  rem_ff,    rem_in;
   logic [1:0]  seqlen_ff, seqlen_in;
   logic [1:0]  hexcnt_ff, hexcnt_in;
   logic [9:0]  hisur_ff,  hisur_in;

   // Result group queue
   grp_type             grp_mem [GRP_DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     grp_cnt_ff, grp_cnt_in;
   logic [1:0]          byte_idx_ff, byte_idx_in;

   logic        req_fire;
   logic        rsp_fire;
   logic        grp_push;
   logic        grp_pop;
   grp_type     grp_in;
   grp_type     grp_cur;

   logic [7:0]  c;
   logic        eod;
   logic        hex_ok;
   logic [3:0]  hex_nib;
   logic [15:0] acc16;
   logic [20:0] raw_acc;
   logic [1:0]  rem_dec;
   logic [20:0] raw_min;
   logic [20:0] pair_cp;
   logic        do_emit;
   logic [20:0] emit_cp;
   logic        do_finish;
   status_type  fin_status;

   assign req_ready = (grp_cnt_ff != CntW'(GRP_DEPTH));
   assign req_fire  = req_valid & req_ready;

   assign c   = req_payload.in_byte;
   assign eod = req_payload.end_of_document;

   // Hex digit of the current byte, and the running \u group and raw
   // sequence values it would build.
   always_comb begin
      hex_ok  = 1'b1;
      hex_nib = c[3:0];
      priority if (c >= 8'h30 && c <= 8'h39) begin
         hex_nib = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         hex_nib = c[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign acc16   = {code_ff[11:0], hex_nib};
   assign raw_acc = {code_ff[14:0], c[5:0]};
   assign rem_dec = rem_ff - 2'd1;
   assign pair_cp = 21'h010000 + {1'b0, hisur_ff, acc16[9:0]};

   always_comb begin
      unique case (seqlen_ff)
         2'd1:    raw_min = 21'h000080;
         2'd2:    raw_min = 21'h000800;
         default: raw_min = 21'h010000;
      endcase
   end

   // Next decoder state and the result group of the current request.
   always_comb begin
      phase_in   = phase_ff;
      code_in    = code_ff;
      rem_in     = rem_ff;
      seqlen_in  = seqlen_ff;
      hexcnt_in  = hexcnt_ff;
      hisur_in   = hisur_ff;
      do_emit    = 1'b0;
      emit_cp    = {13'd0, c};
      do_finish  = 1'b0;
      fin_status = ST_BUSY;

      if (phase_ff == PH_IDLE) begin
         if (eod) begin
            do_finish  = 1'b1;
            fin_status = ST_NOQUOTE;
         end else if (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
            phase_in = PH_IDLE;
         end else if (c == 8'h22) begin
            phase_in = PH_BODY;
         end else begin
            do_finish  = 1'b1;
            fin_status = ST_NOQUOTE;
         end
      end else if (eod) begin
         do_finish  = 1'b1;
         fin_status = ST_EARLY;
      end else begin
         unique case (phase_ff)
            PH_BODY: begin
               priority if (c == 8'h22) begin
                  do_finish  = 1'b1;
                  fin_status = ST_DONE;
               end else if (c < 8'h20) begin
                  do_finish  = 1'b1;
                  fin_status = ST_CTRL;
               end else if (c == 8'h5C) begin
                  phase_in = PH_ESC;
               end else if (c < 8'h80) begin
                  do_emit = 1'b1;
               end else if (c >= 8'hC2 && c <= 8'hDF) begin
                  seqlen_in = 2'd1;
                  rem_in    = 2'd1;
                  code_in   = {16'd0, c[4:0]};
                  phase_in  = PH_RAW;
               end else if (c >= 8'hE0 && c <= 8'hEF) begin
                  seqlen_in = 2'd2;
                  rem_in    = 2'd2;
                  code_in   = {17'd0, c[3:0]};
                  phase_in  = PH_RAW;
               end else if (c >= 8'hF0 && c <= 8'hF4) begin
                  seqlen_in = 2'd3;
                  rem_in    = 2'd3;
                  code_in   = {18'd0, c[2:0]};
                  phase_in  = PH_RAW;
               end else begin
                  do_finish  = 1'b1;
                  fin_status = ST_UTF8;
               end
            end

            PH_ESC: begin
               phase_in = PH_BODY;
               unique case (c)
                  8'h22, 8'h5C, 8'h2F: do_emit = 1'b1;
                  8'h62: begin do_emit = 1'b1; emit_cp = 21'h08; end
                  8'h66: begin do_emit = 1'b1; emit_cp = 21'h0C; end
                  8'h6E: begin do_emit = 1'b1; emit_cp = 21'h0A; end
                  8'h72: begin do_emit = 1'b1; emit_cp = 21'h0D; end
                  8'h74: begin do_emit = 1'b1; emit_cp = 21'h09; end
                  8'h75: begin
                     phase_in  = PH_HEX1;
                     code_in   = '0;
                     hexcnt_in = '0;
                  end
                  default: begin
                     do_finish  = 1'b1;
                     fin_status = ST_ESC;
                  end
               endcase
            end

            PH_HEX1, PH_HEX2: begin
               if (!hex_ok) begin
                  do_finish  = 1'b1;
                  fin_status = ST_HEX;
               end else if (hexcnt_ff != 2'd3) begin
                  code_in   = {5'd0, acc16};
                  hexcnt_in = hexcnt_ff + 2'd1;
               end else begin
                  // Fourth digit: the group is complete.
                  hexcnt_in = '0;
                  code_in   = '0;
                  if (phase_ff == PH_HEX1) begin
                     priority if (acc16 >= 16'hD800 && acc16 <= 16'hDBFF) begin
                        hisur_in = acc16[9:0];
                        phase_in = PH_BSL;
                     end else if (acc16 >= 16'hDC00 && acc16 <= 16'hDFFF) begin
                        do_finish  = 1'b1;
                        fin_status = ST_SURR;
                     end else begin
                        phase_in = PH_BODY;
                        do_emit  = 1'b1;
                        emit_cp  = {5'd0, acc16};
                     end
                  end else begin
                     if (acc16 < 16'hDC00 || acc16 > 16'hDFFF) begin
                        do_finish  = 1'b1;
                        fin_status = ST_SURR;
                     end else begin
                        hisur_in = '0;
                        phase_in = PH_BODY;
                        do_emit  = 1'b1;
                        emit_cp  = pair_cp;
                     end
                  end
               end
            end

            PH_BSL: begin
               if (c != 8'h5C) begin
                  do_finish  = 1'b1;
                  fin_status = ST_SURR;
               end else begin
                  phase_in = PH_U;
               end
            end

            PH_U: begin
               if (c != 8'h75) begin
                  do_finish  = 1'b1;
                  fin_status = ST_SURR;
               end else begin
                  phase_in  = PH_HEX2;
                  code_in   = '0;
                  hexcnt_in = '0;
               end
            end

            PH_RAW: begin
               if (c[7:6] != 2'b10) begin
                  do_finish  = 1'b1;
                  fin_status = ST_UTF8;
               end else if (rem_dec != 2'd0) begin
                  code_in = raw_acc;
                  rem_in  = rem_dec;
               end else if (raw_acc < raw_min || raw_acc > 21'h10FFFF ||
                            (raw_acc >= 21'h00D800 && raw_acc <= 21'h00DFFF)) begin
                  // Overlong, beyond the Unicode range, or a surrogate.
                  do_finish  = 1'b1;
                  fin_status = ST_UTF8;
               end else begin
                  rem_in    = '0;
                  code_in   = '0;
                  seqlen_in = '0;
                  phase_in  = PH_BODY;
                  do_emit   = 1'b1;
                  emit_cp   = raw_acc;
               end
            end

            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      // Any status item puts the whole decoder back to its idle state.
      if (do_finish) begin
         phase_in  = PH_IDLE;
         code_in   = '0;
         rem_in    = '0;
         seqlen_in = '0;
         hexcnt_in = '0;
         hisur_in  = '0;
      end
   end

   always_comb begin
      grp_in = encode_cp(emit_cp);
      if (do_finish) begin
         grp_in           = '0;
         grp_in.is_status = 1'b1;
         grp_in.status    = fin_status;
      end
   end

   assign grp_push = req_fire & (do_emit | do_finish);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         code_ff   <= '0;
         rem_ff    <= '0;
         seqlen_ff <= '0;
         hexcnt_ff <= '0;
         hisur_ff  <= '0;
      end else if (req_fire) begin
         phase_ff  <= phase_in;
         code_ff   <= code_in;
         rem_ff    <= rem_in;
         seqlen_ff <= seqlen_in;
         hexcnt_ff <= hexcnt_in;
         hisur_ff  <= hisur_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result group queue and output side
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (grp_push) begin
         grp_mem[wr_ptr_ff] <= grp_in;
      end
   end

   assign grp_cur   = grp_mem[rd_ptr_ff];
   assign rsp_valid = (grp_cnt_ff != '0);
   assign rsp_fire  = rsp_valid & rsp_ready;

   always_comb begin
      rsp_payload = '0;
      if (grp_cur.is_status) begin
         rsp_payload.status = grp_cur.status;
         rsp_payload.last   = 1'b1;
      end else begin
         rsp_payload.data_byte  = grp_cur.bytes[byte_idx_ff];
         rsp_payload.byte_valid = 1'b1;
         rsp_payload.status     = ST_BUSY;
         rsp_payload.last       = (byte_idx_ff == grp_cur.last_idx);
      end
   end

   assign grp_pop = rsp_fire & rsp_payload.last;

   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      byte_idx_in = byte_idx_ff;
      grp_cnt_in  = grp_cnt_ff;
      if (grp_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(GRP_DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (grp_pop) begin
         rd_ptr_in   = (rd_ptr_ff == PtrW'(GRP_DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
         byte_idx_in = '0;
      end else if (rsp_fire) begin
         byte_idx_in = byte_idx_ff + 2'd1;
      end
      if (grp_push && !grp_pop) begin
         grp_cnt_in = grp_cnt_ff + CntW'(1);
      end else if (grp_pop && !grp_push) begin
         grp_cnt_in = grp_cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         byte_idx_ff <= '0;
         grp_cnt_ff  <= '0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         byte_idx_ff <= byte_idx_in;
         grp_cnt_ff  <= grp_cnt_in;
      end
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      grp_cnt_ff <= CntW'(GRP_DEPTH))
      else $error("result queue holds more groups than it has room for");

   a_status_idles: assert property (@(posedge clock) disable iff (reset)
      (req_fire && do_finish) |=> (phase_ff == PH_IDLE && code_ff == '0 &&
                                   hisur_ff == '0 && hexcnt_ff == '0))
      else $error("decoder not idle after a status result");

   a_idx_in_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (byte_idx_ff <= grp_cur.last_idx || grp_cur.is_status))
      else $error("byte index runs past the end of its group");

   a_idx_clear_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> (byte_idx_ff == '0 && rd_ptr_ff == wr_ptr_ff))
      else $error("empty queue with a stale read position");

   a_status_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && grp_cur.is_status) |-> (byte_idx_ff == '0))
      else $error("status group entered part way through");

endmodule
